@@ src/hcad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcad_pkg
// Types, constants and the pixel colour function of the hi-res colour
// artifact decoder.
// ----------------------------------------------------------------------------
package hcad_pkg;

    localparam int unsigned BytesDots   = 7;
    localparam int unsigned PairPixels  = 2 * BytesDots;
    // d(-1) .. d(14)
    localparam int unsigned DotVecW     = PairPixels + 2;
    localparam int unsigned PixIdxW     = $clog2(PairPixels);
    localparam int unsigned QueueDepth  = 2;
    localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
    localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

    localparam logic [PixIdxW-1:0] LastPixIdx = PixIdxW'(PairPixels - 1);
    localparam logic [PixIdxW-1:0] FirstOwner2 = PixIdxW'(BytesDots);

    localparam int unsigned PaletteBit  = 7;

    localparam logic [2:0] ColBlack   = 3'd0;
    localparam logic [2:0] ColGreen   = 3'd1;
    localparam logic [2:0] ColPurple  = 3'd2;
    localparam logic [2:0] ColWhite   = 3'd3;
    localparam logic [2:0] PalOffset  = 3'd4;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       following_bit;
        logic       row_start;
    } t_in_item;

    typedef struct packed {
        logic [2:0] pixel_color;
        logic       run_last;
    } t_out_item;

    // Classified pair: bit 0 is d(-1), bit 15 is d(14)
    typedef struct packed {
        logic [DotVecW-1:0] dots;
        logic [1:0]         palette;
    } t_job;

    typedef struct packed {
        logic push;
        logic full;
    } t_q_wr;

    typedef struct packed {
        logic pop;
        logic valid;
    } t_q_rd;

    // win[0] = dot before pair, win[1..2] = pair, win[3] = dot after pair
    function automatic logic [2:0] pixel_code(input logic [3:0] win,
                                              input logic       odd,
                                              input logic       pal);
        logic [2:0] code;
        logic       side;
        logic       ref_dot;
        begin
            side    = odd ? win[2] : win[1];
            ref_dot = odd ? win[3] : win[0];
            if (win[1] == win[2]) begin
                code = win[1] ? ColWhite : ColBlack;
            end else if (odd) begin
                if (side) code = ref_dot ? ColWhite : ColGreen;
                else      code = ref_dot ? ColPurple : ColBlack;
            end else begin
                if (ref_dot) code = side ? ColWhite : ColGreen;
                else         code = side ? ColPurple : ColBlack;
            end
            pixel_code = pal ? (code + PalOffset) : code;
        end
    endfunction

endpackage

@@ src/hcad_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcad_front
// Accepts byte pairs, builds the dot vector with the kept previous dot and
// pushes the classified pair into the queue.
// ----------------------------------------------------------------------------
module hcad_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hcad_pkg::t_in_item i_in_data,
    input  logic              i_q_full,
    output hcad_pkg::t_q_wr   o_q_wr,
    output hcad_pkg::t_job    o_job
);
    import hcad_pkg::*;

    logic r_prev_dot;
    logic n_prev_dot;
    logic prev_eff;
    logic push;

    assign o_in_ready = !i_q_full;
    assign push       = i_in_valid && !i_q_full;
    assign prev_eff   = i_in_data.row_start ? 1'b0 : r_prev_dot;

    assign o_job.dots    = {i_in_data.following_bit,
                            i_in_data.second_byte[BytesDots-1:0],
                            i_in_data.first_byte[BytesDots-1:0],
                            prev_eff};
    assign o_job.palette = {i_in_data.second_byte[PaletteBit],
                            i_in_data.first_byte[PaletteBit]};

    assign o_q_wr.push = push;
    assign o_q_wr.full = i_q_full;

    // d13 carries over to the next pair
    assign n_prev_dot = push ? i_in_data.second_byte[BytesDots-1] : r_prev_dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_dot <= 1'b0;
        end else begin
            r_prev_dot <= n_prev_dot;
        end
    end

endmodule

@@ src/hcad_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcad_queue
// Short FIFO of classified pairs between the front and the back.
// ----------------------------------------------------------------------------
module hcad_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hcad_pkg::t_q_wr i_wr,
    input  hcad_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output hcad_pkg::t_q_rd o_rd,
    output hcad_pkg::t_job  o_job
);
    import hcad_pkg::*;

    t_job                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr;
    logic [QueueCntW-1:0] r_count;
    logic [QueuePtrW-1:0] n_wr_ptr;
    logic [QueuePtrW-1:0] n_rd_ptr;
    logic [QueueCntW-1:0] n_count;
    logic                 pop;

    assign o_full     = (r_count == QueueCntW'(QueueDepth));
    assign o_rd.valid = (r_count != '0);
    assign pop        = i_pop && o_rd.valid;
    assign o_rd.pop   = pop;
    assign o_job      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr.push) begin
            n_wr_ptr = (r_wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr.push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr.push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QueueCntW'(QueueDepth))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.push |-> !i_wr.full && !o_full)
        else $error("push into full queue");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_wr.push) |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count not reduced on pop");
`endif

endmodule

@@ src/hcad_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcad_back
// Walks one classified pair a pixel per cycle while the output is not
// stalled, and drives the registered output channel.
// ----------------------------------------------------------------------------
module hcad_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hcad_pkg::t_q_rd    i_rd,
    input  hcad_pkg::t_job     i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hcad_pkg::t_out_item o_out_data
);
    import hcad_pkg::*;

    t_job               r_cur;
    logic               r_busy;
    logic [PixIdxW-1:0] r_idx;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               n_busy;
    logic [PixIdxW-1:0] n_idx;
    logic               adv;
    logic               emit;
    logic               last;
    logic               pop;
    logic [3:0]         win;
    logic               pal;

    assign adv  = !r_out_valid || i_out_ready;
    assign emit = adv && r_busy;
    assign last = (r_idx == LastPixIdx);
    assign pop  = i_rd.valid && (!r_busy || (emit && last));

    // pixel i uses dots d(2k-1)..d(2k+2), k = i/2
    assign win = r_cur.dots[{r_idx[PixIdxW-1:1], 1'b0} +: 4];
    assign pal = (r_idx < FirstOwner2) ? r_cur.palette[0] : r_cur.palette[1];

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (emit) begin
            n_idx = last ? '0 : r_idx + 1'b1;
            if (last) n_busy = 1'b0;
        end
        if (pop) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            if (adv) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur <= i_job;
        end
        if (emit) begin
            r_out.pixel_color <= pixel_code(win, r_idx[0], pal);
            r_out.run_last    <= last;
        end
    end

    assign o_pop       = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LastPixIdx)
        else $error("pixel index out of range");

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_idx == '0)
        else $error("pixel index not at start while idle");

    a_last_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out.run_last == (r_idx == '0))
        else $error("run_last out of step with pixel index");
`endif

endmodule

@@ src/hires_color_artifact_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hires_color_artifact_decoder
// Turns hi-res video byte pairs into fourteen colour codes each.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one byte pair
//   per transaction, with bit 0 of the next byte and a row start flag.
//   Output channel (o_out_valid / i_out_ready / o_out_data) gives fourteen
//   transactions per pair, left to right; run_last marks the fourteenth.
//   Each pair passes the queue and the back end's pair register before
//   its pixels reach the output. Throughput: one pixel per clock from the
//   back end's pixel counter unless the receiver stalls. A two-entry queue
//   lets up to two pairs be taken ahead of the pixel stream; o_in_ready
//   drops only when it fills. The kept previous dot is updated as each
//   pair is taken. Reset (synchronous, active low) empties the queue, drops
//   any pixels in flight and clears the kept previous dot.
//   When the receiver stalls, the current pixel holds on the output and
//   the pixel walk pauses; input is still taken until the queue is full.
// ----------------------------------------------------------------------------
module hires_color_artifact_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hcad_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hcad_pkg::t_out_item o_out_data
);
    import hcad_pkg::*;

    t_q_wr q_wr;
    t_q_rd q_rd;
    t_job  front_job;
    t_job  queue_job;
    logic  q_full;
    logic  back_pop;

    hcad_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_q_wr     (q_wr),
        .o_job      (front_job)
    );

    hcad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_rd    (q_rd),
        .o_job   (queue_job)
    );

    hcad_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (q_rd),
        .i_job       (queue_job),
        .o_pop       (back_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
